// File: sv/bas_pkg.sv
// Package for the bitonic array search block: beat types, action codes and sequencer states.
`default_nettype none

package bas_pkg;

	localparam int ELEM_W = 32;
	localparam int PEAK_W = 10;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;

	// Flipping the sign bit makes unsigned order match signed order.
	localparam logic [ELEM_W-1:0] SIGN_FLIP = 32'h8000_0000;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [ELEM_W-1:0] value;
	} bas_req_t;

	typedef struct packed {
		logic              found;
		logic [PEAK_W-1:0] peak_index;
	} bas_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PK_TEST,
		ST_PK_BL,
		ST_PK_BH,
		ST_PK_M,
		ST_PK_L,
		ST_PK_R,
		ST_SR_TEST,
		ST_SR_CMP,
		ST_DONE
	} bas_state_t;

endpackage

`default_nettype wire

// File: sv/bas_ram.sv
// Element store: one write port and one read port with registered read data.
`default_nettype none

module bas_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [bas_pkg::ELEM_W-1:0] wr_data,
	input  wire logic [AW-1:0]              rd_addr,
	output logic      [bas_pkg::ELEM_W-1:0] rd_data
);
	import bas_pkg::*;

	logic [ELEM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/bitonic_array_search.sv
// Top level of the bitonic array search block: sequencer, search registers and result register.
`default_nettype none

// Channel   Direction  Handshake              Beat contents
// req       in         req_valid / req_ready  action, value (clear, append or query)
// rsp       out        rsp_valid / rsp_ready  found, peak_index (one beat per query)
//
// A clear or an append is taken straight from the idle state. A query halves the peak
// range, reading the middle element, then its left and if needed its right neighbor, compares
// the last two candidates, runs the binary searches of the rising and then the falling part,
// and loads the result. Reset empties the array through the count.
// req_ready is high only while the sequencer is idle; clears and appends are taken while a
// result waits, but a second query holds its result until the first has been taken.

module bitonic_array_search #(
	parameter int CAPACITY = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire bas_pkg::bas_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output bas_pkg::bas_rsp_t      rsp
);
	import bas_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	bas_state_t state_q, state_d;

	// Element count and result handshake; with the sequencer state, the only registers reset clears.
	logic [CW-1:0] count_q, count_d;
	logic          rsp_valid_q;
	bas_rsp_t      rsp_q;

	// Peak search range, probe index, the element captured at the probe, the peak index and the key.
	logic [AW-1:0] lo_q, lo_d;
	logic [AW-1:0] hi_q, hi_d;
	logic [AW-1:0] mid_q, mid_d;
	logic [AW-1:0] peak_q, peak_d;
	logic [ELEM_W-1:0] elem_q, elem_d;
	logic [ELEM_W-1:0] key_q, key_d;

	// Binary search range as low bound and exclusive high bound.
	logic [CW-1:0] slo_q, slo_d;
	logic [CW-1:0] shx_q, shx_d;
	logic          rising_q, rising_d;
	logic          found_q, found_d;

	logic              req_acc;
	logic              load_rsp;
	logic              wr_en;
	logic [AW-1:0]     rd_addr;
	logic [ELEM_W-1:0] rd_data;
	logic [ELEM_W-1:0] biased;

	// The one shared comparator, steered by the sequencer.
	logic [ELEM_W-1:0] cmp_x, cmp_y;
	logic              cmp_gt, cmp_eq;

	logic [AW:0]   pk_sum;
	logic [CW:0]   sr_sum;
	logic [AW-1:0] pk_mid;
	logic [AW-1:0] sr_mid;
	logic [AW-1:0] pk_sel;

	assign req_acc   = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign biased    = req.value ^ SIGN_FLIP;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cmp_gt = cmp_x > cmp_y;
	assign cmp_eq = cmp_x == cmp_y;

	assign pk_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign pk_mid = pk_sum[AW:1];
	assign sr_sum = {1'b0, slo_q} + {1'b0, shx_q} - (CW + 1)'(1);
	assign sr_mid = sr_sum[AW:1];
	assign pk_sel = cmp_gt ? lo_q : hi_q;

	bas_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (biased),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		mid_q    <= mid_d;
		peak_q   <= peak_d;
		elem_q   <= elem_d;
		key_q    <= key_d;
		slo_q    <= slo_d;
		shx_q    <= shx_d;
		rising_q <= rising_d;
		found_q  <= found_d;
		if (load_rsp) begin
			rsp_q.found      <= found_q;
			rsp_q.peak_index <= PEAK_W'(peak_q);
		end
	end

	// Comparator operands: the fresh read against the held probe by default. The final pair
	// of the peak search compares the held left element against the right one, and a search
	// probe compares the fresh read against the key.
	always_comb begin
		cmp_x = rd_data;
		cmp_y = elem_q;
		case (state_q)
			ST_PK_BH: begin
				cmp_x = elem_q;
				cmp_y = rd_data;
			end
			ST_SR_CMP: begin
				cmp_y = key_q;
			end
			default: begin
			end
		endcase
	end

	// Each state issues at most one memory read; the data is seen by the next state.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		mid_d    = mid_q;
		peak_d   = peak_q;
		elem_d   = elem_q;
		key_d    = key_q;
		slo_d    = slo_q;
		shx_d    = shx_q;
		rising_d = rising_q;
		found_d  = found_q;
		rd_addr  = mid_q;
		wr_en    = 1'b0;
		load_rsp = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					case (req.action)
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_APPEND: begin
							// An append to a full array is dropped.
							if (count_q < CW'(CAPACITY)) begin
								wr_en   = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						ACT_QUERY: begin
							key_d = biased;
							if (count_q == '0) begin
								found_d = 1'b0;
								peak_d  = '0;
								state_d = ST_DONE;
							end else begin
								lo_d    = '0;
								hi_d    = AW'(count_q - CW'(1));
								state_d = ST_PK_TEST;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_PK_TEST: begin
				if (({1'b0, lo_q} + (AW + 1)'(1)) >= {1'b0, hi_q}) begin
					rd_addr = lo_q;
					state_d = ST_PK_BL;
				end else begin
					mid_d   = pk_mid;
					rd_addr = pk_mid;
					state_d = ST_PK_M;
				end
			end
			ST_PK_BL: begin
				elem_d  = rd_data;
				rd_addr = hi_q;
				state_d = ST_PK_BH;
			end
			ST_PK_BH: begin
				// The left element wins only when strictly greater.
				peak_d   = pk_sel;
				slo_d    = '0;
				shx_d    = CW'(pk_sel) + CW'(1);
				rising_d = 1'b1;
				state_d  = ST_SR_TEST;
			end
			ST_PK_M: begin
				elem_d  = rd_data;
				rd_addr = mid_q - AW'(1);
				state_d = ST_PK_L;
			end
			ST_PK_L: begin
				if (cmp_gt) begin
					hi_d    = mid_q - AW'(1);
					state_d = ST_PK_TEST;
				end else begin
					rd_addr = mid_q + AW'(1);
					state_d = ST_PK_R;
				end
			end
			ST_PK_R: begin
				if (cmp_gt) begin
					lo_d    = mid_q + AW'(1);
					state_d = ST_PK_TEST;
				end else begin
					peak_d   = mid_q;
					slo_d    = '0;
					shx_d    = CW'(mid_q) + CW'(1);
					rising_d = 1'b1;
					state_d  = ST_SR_TEST;
				end
			end
			ST_SR_TEST: begin
				if (slo_q >= shx_q) begin
					if (rising_q) begin
						slo_d    = CW'(peak_q) + CW'(1);
						shx_d    = count_q;
						rising_d = 1'b0;
					end else begin
						found_d = 1'b0;
						state_d = ST_DONE;
					end
				end else begin
					mid_d   = sr_mid;
					rd_addr = sr_mid;
					state_d = ST_SR_CMP;
				end
			end
			ST_SR_CMP: begin
				if (cmp_eq) begin
					found_d = 1'b1;
					state_d = ST_DONE;
				end else if (cmp_gt == rising_q) begin
					shx_d   = CW'(mid_q);
					state_d = ST_SR_TEST;
				end else begin
					slo_d   = CW'(mid_q) + CW'(1);
					state_d = ST_SR_TEST;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// An append with room grows the count by exactly one.
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.action == ACT_APPEND && count_q < CW'(CAPACITY)
		|=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance the element count");

	// A clear empties the array on the next cycle.
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req.action == ACT_CLEAR |=> count_q == '0)
		else $error("clear did not empty the array");

	// The peak search range stays ordered and inside the stored elements.
	a_peak_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PK_TEST |-> lo_q <= hi_q && CW'(hi_q) < count_q)
		else $error("peak search range out of bounds");

	// A result is loaded only when the result register is free or being emptied.
	a_rsp_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && rsp_valid_q && !rsp_ready |=> state_q == ST_DONE)
		else $error("result overwrote a beat still waiting");

endmodule

`default_nettype wire

// File: bench/bitonic_array_search_test.sv
// Self-checking bench for bitonic_array_search: directed rows and random ridges.
module bitonic_array_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bas_pkg::*;

	localparam int CAP = 1024;
	// The package names only the three live actions; the fourth code is ignored by the block.
	localparam logic [1:0] ACT_RESERVED = 2'd3;
	// A query on a full array, and a stalled result on top of it, keep both channels quiet;
	// a quiet spell that reaches STALL_LIMIT means the block is stuck.
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;
	localparam int BEATS_PER_PHASE = 180;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	bas_req_t req;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	bas_rsp_t rsp;

	bitonic_array_search #(.CAPACITY(CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the array. Only entries below shadow_count are ever read, and every one
	// of those was written by an append since the last clear, so unwritten entries never matter.
	logic signed [ELEM_W-1:0] shadow_elems [CAP];
	int unsigned              shadow_count = 0;

	// Answers owed by the block, oldest first.
	bas_rsp_t pending_answers [$];
	bas_rsp_t oldest;

	// The values of the current random sequence, kept so that keys can be drawn from them.
	logic signed [ELEM_W-1:0] ridge [$];

	int mismatches = 0;
	int beats_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	typedef struct packed {
		logic [1:0]               action;
		logic signed [ELEM_W-1:0] value;
		logic                     has_want;
		logic                     want_found;
		logic [PEAK_W-1:0]        want_peak;
	} stim_row_t;

	// Directed rows. Where the answer is obvious by inspection it is typed in; the rest go
	// through the predictor like the random traffic does.
	stim_row_t directed_rows [25] = '{
		// Query right out of reset: the array is empty.
		'{ACT_QUERY,    32'sd0,            1'b1, 1'b0, 10'd0},
		// The reserved action must change nothing, so the array stays empty.
		'{ACT_RESERVED, 32'sd77,           1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    32'sd5,            1'b1, 1'b0, 10'd0},
		// A ridge running from the most negative value up to the most positive one and back down.
		'{ACT_APPEND,   32'sh8000_0000,    1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   -32'sd7,           1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   32'sh7FFF_FFFF,    1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   32'sd12,           1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   32'sh8000_0000,    1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    32'sh7FFF_FFFF,    1'b1, 1'b1, 10'd2},
		'{ACT_QUERY,    32'sh8000_0000,    1'b1, 1'b1, 10'd2},
		'{ACT_QUERY,    32'sd11,           1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    -32'sd1,           1'b0, 1'b0, 10'd0},
		// After a clear the array is empty again.
		'{ACT_CLEAR,    32'sh5A5A_A5A5,    1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    32'sh8000_0000,    1'b1, 1'b0, 10'd0},
		// Two equal elements: the left one is not strictly greater, so the right one is the peak.
		'{ACT_APPEND,   32'sd4,            1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   32'sd4,            1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    32'sd4,            1'b1, 1'b1, 10'd1},
		// A single element is its own peak.
		'{ACT_CLEAR,    -32'sd1,           1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   -32'sd1,           1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    -32'sd1,           1'b1, 1'b1, 10'd0},
		'{ACT_QUERY,    32'sd0,            1'b1, 1'b0, 10'd0},
		// An array that is not unimodal still follows the same probe sequence.
		'{ACT_APPEND,   32'sd9,            1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   -32'sd20,          1'b0, 1'b0, 10'd0},
		'{ACT_APPEND,   32'sd15,           1'b0, 1'b0, 10'd0},
		'{ACT_QUERY,    32'sd15,           1'b0, 1'b0, 10'd0}
	};

	task automatic note_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Peak search over [0, top]: halve on neighbor comparisons with strict greater-than.
	function automatic int unsigned locate_peak(int unsigned top);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = top;
		forever begin
			if (lo + 1 >= hi)
				return (shadow_elems[lo] > shadow_elems[hi]) ? lo : hi;
			mid = (lo + hi) / 2;
			if (shadow_elems[mid - 1] > shadow_elems[mid])
				hi = mid - 1;
			else if (shadow_elems[mid + 1] > shadow_elems[mid])
				lo = mid + 1;
			else
				return mid;
		end
	endfunction

	// Binary search of [lo, hi], in ascending order when rising is set, else descending.
	function automatic bit scan_part(logic signed [ELEM_W-1:0] key, int lo, int hi, bit rising);
		int                       mid;
		logic signed [ELEM_W-1:0] probe;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			probe = shadow_elems[mid];
			if (key == probe)
				return 1'b1;
			if ((key < probe) == rising)
				hi = mid - 1;
			else
				lo = mid + 1;
		end
		return 1'b0;
	endfunction

	function automatic bas_rsp_t predict_query(logic signed [ELEM_W-1:0] key);
		int unsigned last;
		int unsigned peak;
		bit          hit;
		bas_rsp_t    answer;
		answer = '0;
		if (shadow_count == 0)
			return answer;
		last = shadow_count - 1;
		peak = locate_peak(last);
		hit = scan_part(key, 0, int'(peak), 1'b1);
		if (!hit)
			hit = scan_part(key, int'(peak) + 1, int'(last), 1'b0);
		answer.found = hit;
		answer.peak_index = peak[PEAK_W-1:0];
		return answer;
	endfunction

	// Present one beat, hold it until the block takes it, then fold it into the shadow state.
	// The shadow update waits for the falling edge after acceptance, so a result beat can never
	// race the expectation of its own query within one time step.
	task automatic send_beat(logic [1:0] act, logic signed [ELEM_W-1:0] val,
			bit has_want = 1'b0, bas_rsp_t want = '0);
		bas_req_t beat;
		beat.action = act;
		beat.value = val;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= beat;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		case (act)
			ACT_CLEAR: begin
				shadow_count = 0;
			end
			ACT_APPEND: begin
				// Appends past the capacity are dropped without a trace.
				if (shadow_count < CAP) begin
					shadow_elems[shadow_count] = val;
					shadow_count++;
				end
			end
			ACT_QUERY: begin
				pending_answers.push_back(has_want ? want : predict_query(val));
			end
			default: begin
			end
		endcase
		if (act != ACT_RESERVED)
			beats_sent++;
	endtask

	// Random traffic occasionally slips an ignored beat in ahead of a real one.
	task automatic send_with_noise(logic [1:0] act, logic signed [ELEM_W-1:0] val);
		if ($urandom_range(99) < 3)
			send_beat(ACT_RESERVED, $urandom);
		send_beat(act, val);
	endtask

	// Fill the ridge queue with n values that rise to a random peak and then fall. Steps of
	// zero give plateaus. The base is placed so that neither side can leave the 32-bit range.
	task automatic build_ridge(int n, int unsigned step_max);
		longint span;
		longint lvl;
		int     pk;
		ridge.delete();
		if (n == 0)
			return;
		span = longint'(n) * step_max;
		lvl = -64'sd2147483648 + span + (longint'($urandom) % (64'sd4294967296 - 2 * span));
		pk = $urandom_range(0, n - 1);
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				if (i <= pk)
					lvl += $urandom_range(0, step_max);
				else
					lvl -= $urandom_range(0, step_max);
			end
			ridge.push_back(lvl[ELEM_W-1:0]);
		end
	endtask

	// Keys are mostly stored values or their near neighbors, since those steer the searches
	// to their last probes; the rest are arbitrary words and the two extremes.
	function automatic logic signed [ELEM_W-1:0] pick_key();
		int                       roll;
		logic signed [ELEM_W-1:0] k;
		roll = $urandom_range(99);
		if (ridge.size() != 0 && roll < 55)
			k = ridge[$urandom_range(0, ridge.size() - 1)];
		else if (ridge.size() != 0 && roll < 75)
			k = ridge[$urandom_range(0, ridge.size() - 1)] + ($urandom_range(1) ? 1 : -1);
		else if (roll < 90)
			k = $urandom;
		else
			k = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		return k;
	endfunction

	// One random sequence: usually a clear, a well-formed ridge and a few queries; now and
	// then a run of arbitrary values, possibly on top of whatever the array already holds.
	task automatic random_episode();
		int          n;
		int unsigned step_max;
		if ($urandom_range(99) < 12) begin
			if ($urandom_range(1))
				send_with_noise(ACT_CLEAR, $urandom);
			n = $urandom_range(0, 10);
			ridge.delete();
			repeat (n)
				ridge.push_back($urandom);
		end else begin
			send_with_noise(ACT_CLEAR, $urandom);
			n = ($urandom_range(99) < 5) ? $urandom_range(41, 300) : $urandom_range(0, 40);
			case ($urandom_range(2))
				0: step_max = 1;
				1: step_max = 8;
				default: step_max = (n <= 60) ? (1 << 24) : 8;
			endcase
			build_ridge(n, step_max);
		end
		for (int i = 0; i < ridge.size(); i++)
			send_with_noise(ACT_APPEND, ridge[i]);
		repeat ($urandom_range(1, 6))
			send_with_noise(ACT_QUERY, pick_key());
	endtask

	// The receiver decides afresh on every cycle whether to stall.
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Every result beat is matched against the oldest answer still owed.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (pending_answers.size() == 0) begin
				note_mismatch($sformatf("result beat with no query waiting: found=%0b peak_index=%0d",
					rsp.found, rsp.peak_index));
			end else begin
				oldest = pending_answers.pop_front();
				if (rsp.found !== oldest.found)
					note_mismatch($sformatf("found is %0b, expected %0b (peak_index %0d)",
						rsp.found, oldest.found, oldest.peak_index));
				if (rsp.peak_index !== oldest.peak_index)
					note_mismatch($sformatf("peak_index is %0d, expected %0d",
						rsp.peak_index, oldest.peak_index));
			end
		end
	end

	// The watchdog ends the run when neither channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("timeout: no beat for %0d cycles, %0d answers outstanding",
				STALL_LIMIT, pending_answers.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		bas_rsp_t typed;
		int       phase_end;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows run with both sides always ready.
		foreach (directed_rows[i]) begin
			typed.found = directed_rows[i].want_found;
			typed.peak_index = directed_rows[i].want_peak;
			send_beat(directed_rows[i].action, directed_rows[i].value,
				directed_rows[i].has_want, typed);
		end

		// Random traffic in four idling phases: none, a sparse sender, a slow receiver, and
		// a light mix of both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			phase_end = beats_sent + BEATS_PER_PHASE;
			while (beats_sent < phase_end)
				random_episode();
		end
		req_valid <= 1'b0;

		// Let every owed answer arrive, then give the block time to show any extra beat.
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
